>>> hw/rtl/mac_address_packet_counter_assert.svh
// Assertion helpers shared by the RTL of the MAC address packet counter.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef MAC_ADDRESS_PACKET_COUNTER_ASSERT_SVH
`define MAC_ADDRESS_PACKET_COUNTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MACPC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MACPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/macpc_pkg.sv
`timescale 1ns / 1ps

package macpc_pkg;

    localparam int MAC_WIDTH       = 48;
    localparam int STATUS_WIDTH    = 3;
    localparam int INDEX_WIDTH     = 7;
    localparam int COUNT_OUT_WIDTH = 32;
    localparam int USED_OUT_WIDTH  = 8;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_HIT        = 3'd0,
        ST_NEW        = 3'd1,
        ST_FULL       = 3'd2,
        ST_READ_OK    = 3'd3,
        ST_READ_EMPTY = 3'd4
    } status_t;

    typedef enum logic {
        OP_COUNT = 1'b0,
        OP_READ  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN
    } state_t;

endpackage

>>> hw/rtl/mac_address_packet_counter.sv
// MAC address packet counter. A beat is taken when start is high and busy is low. A count
// beat looks the key up by reading the stored entries one per cycle from index 0, then bumps
// the matching count (saturating), appends the key with a count of one, or reports the table
// full; a read beat fetches one entry or reports it empty. Every beat yields exactly one
// result, shown for a single cycle with done high; the receiver cannot stall it, so it must
// take the result in that cycle. How long a count beat takes is set by the scan through the
// single-port key/count memory, one entry per cycle. busy drops in the cycle the result
// appears, so the next beat can be taken while the result is shown.
`timescale 1ns / 1ps

module mac_address_packet_counter #(
    parameter int TABLE_DEPTH = 128,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   opcode,
    input  logic [macpc_pkg::MAC_WIDTH-1:0]        mac_key,
    input  logic [macpc_pkg::INDEX_WIDTH-1:0]      read_index,
    output logic                                   done,
    output logic [macpc_pkg::STATUS_WIDTH-1:0]     status,
    output logic [macpc_pkg::INDEX_WIDTH-1:0]      entry_index,
    output logic [macpc_pkg::MAC_WIDTH-1:0]        entry_mac,
    output logic [macpc_pkg::COUNT_OUT_WIDTH-1:0]  packet_count,
    output logic [macpc_pkg::USED_OUT_WIDTH-1:0]   entries_in_use
);

    import macpc_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int UW = $clog2(TABLE_DEPTH + 1);
    localparam int RW = (UW > INDEX_WIDTH) ? UW : INDEX_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Key and count storage, one shared address port.
    logic [MAC_WIDTH-1:0]   key_mem [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] cnt_mem [TABLE_DEPTH];

    logic [MAC_WIDTH-1:0]   key_rd_reg;
    logic [COUNT_WIDTH-1:0] cnt_rd_reg;
    logic [IW-1:0]          mem_addr;
    logic                   mem_we;
    logic [MAC_WIDTH-1:0]   mem_wr_key;
    logic [COUNT_WIDTH-1:0] mem_wr_cnt;

    state_t                 state_reg, state_next;
    logic [UW-1:0]          used_reg, used_next;
    logic [IW-1:0]          scan_idx_reg, scan_idx_next;
    logic [MAC_WIDTH-1:0]   key_reg, key_next;

    logic                       done_reg, done_next;
    status_t                    status_reg, status_next;
    logic [INDEX_WIDTH-1:0]     index_reg, index_next;
    logic [MAC_WIDTH-1:0]       mac_reg, mac_next;
    logic [COUNT_OUT_WIDTH-1:0] count_reg, count_next;

    logic                   read_valid;
    logic [UW-1:0]          scan_idx_inc;
    logic [COUNT_WIDTH-1:0] cnt_bumped;

    assign read_valid   = RW'(read_index) < RW'(used_reg);
    assign scan_idx_inc = UW'(scan_idx_reg) + UW'(1);
    assign cnt_bumped   = (cnt_rd_reg == COUNT_MAX) ? cnt_rd_reg : cnt_rd_reg + COUNT_WIDTH'(1);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[mem_addr] <= mem_wr_key;
            cnt_mem[mem_addr] <= mem_wr_cnt;
        end
        key_rd_reg <= key_mem[mem_addr];
        cnt_rd_reg <= cnt_mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        key_reg      <= key_next;
        status_reg   <= status_next;
        index_reg    <= index_next;
        mac_reg      <= mac_next;
        count_reg    <= count_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        used_next     = used_reg;
        scan_idx_next = scan_idx_reg;
        key_next      = key_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        index_next    = index_reg;
        mac_next      = mac_reg;
        count_next    = count_reg;
        mem_addr      = scan_idx_reg;
        mem_we        = 1'b0;
        mem_wr_key    = key_reg;
        mem_wr_cnt    = cnt_bumped;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    key_next = mac_key;
                    if (opcode_t'(opcode) == OP_READ)
                    begin
                        if (read_valid)
                        begin
                            mem_addr      = IW'(read_index);
                            scan_idx_next = IW'(read_index);
                            state_next    = S_READ;
                        end
                        else
                        begin
                            done_next   = 1'b1;
                            status_next = ST_READ_EMPTY;
                            index_next  = read_index;
                            mac_next    = '0;
                            count_next  = '0;
                        end
                    end
                    else if (used_reg == '0)
                    begin
                        // Empty table: the key goes straight into entry 0.
                        mem_addr    = '0;
                        mem_we      = 1'b1;
                        mem_wr_key  = mac_key;
                        mem_wr_cnt  = COUNT_WIDTH'(1);
                        used_next   = UW'(1);
                        done_next   = 1'b1;
                        status_next = ST_NEW;
                        index_next  = '0;
                        mac_next    = mac_key;
                        count_next  = COUNT_OUT_WIDTH'(1);
                    end
                    else
                    begin
                        mem_addr      = '0;
                        scan_idx_next = '0;
                        state_next    = S_SCAN;
                    end
                end
            end

            S_READ:
            begin
                done_next   = 1'b1;
                status_next = ST_READ_OK;
                index_next  = INDEX_WIDTH'(scan_idx_reg);
                mac_next    = key_rd_reg;
                count_next  = COUNT_OUT_WIDTH'(cnt_rd_reg);
                state_next  = S_IDLE;
            end

            S_SCAN:
            begin
                // The read data belongs to scan_idx_reg, whose address was issued in the previous cycle.
                if (key_rd_reg == key_reg)
                begin
                    mem_addr    = scan_idx_reg;
                    mem_we      = 1'b1;
                    mem_wr_key  = key_rd_reg;
                    mem_wr_cnt  = cnt_bumped;
                    done_next   = 1'b1;
                    status_next = ST_HIT;
                    index_next  = INDEX_WIDTH'(scan_idx_reg);
                    mac_next    = key_rd_reg;
                    count_next  = COUNT_OUT_WIDTH'(cnt_bumped);
                    state_next  = S_IDLE;
                end
                else if (scan_idx_inc < used_reg)
                begin
                    mem_addr      = IW'(scan_idx_inc);
                    scan_idx_next = IW'(scan_idx_inc);
                end
                else if (used_reg == UW'(TABLE_DEPTH))
                begin
                    done_next   = 1'b1;
                    status_next = ST_FULL;
                    index_next  = '0;
                    mac_next    = key_reg;
                    count_next  = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    mem_addr    = IW'(used_reg);
                    mem_we      = 1'b1;
                    mem_wr_key  = key_reg;
                    mem_wr_cnt  = COUNT_WIDTH'(1);
                    used_next   = used_reg + UW'(1);
                    done_next   = 1'b1;
                    status_next = ST_NEW;
                    index_next  = INDEX_WIDTH'(used_reg);
                    mac_next    = key_reg;
                    count_next  = COUNT_OUT_WIDTH'(1);
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign entry_index    = index_reg;
    assign entry_mac      = mac_reg;
    assign packet_count   = count_reg;
    assign entries_in_use = USED_OUT_WIDTH'(used_reg);

`include "mac_address_packet_counter_assert.svh"

    `MACPC_ASSERT_SAME(a_used_bounded, 1'b1, used_reg <= UW'(TABLE_DEPTH), "fill count overflow")
    `MACPC_ASSERT_SAME(a_done_in_idle, done_reg, state_reg == S_IDLE, "result while still busy")
    `MACPC_ASSERT_NEXT(a_beat_progress, start && !busy, busy || done_reg, "beat taken but lost")
    `MACPC_ASSERT_SAME(a_used_only_on_new, used_reg != $past(used_reg),
        done_reg && status_reg == ST_NEW && used_reg == $past(used_reg) + UW'(1),
        "fill count moved without an insert")
    `MACPC_ASSERT_SAME(a_scan_in_range, state_reg == S_SCAN, UW'(scan_idx_reg) < used_reg,
        "scan past the occupied entries")

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import macpc_pkg::*;

    localparam int DEPTH        = 128;
    localparam int RANDOM_BEATS = 1585;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        opcode_t                     op;
        logic [MAC_WIDTH-1:0]        key;
        logic [INDEX_WIDTH-1:0]      idx;
    } packet_beat_t;

    typedef struct {
        status_t                     st;
        logic [INDEX_WIDTH-1:0]      idx;
        logic [MAC_WIDTH-1:0]        mac;
        logic [COUNT_OUT_WIDTH-1:0]  cnt;
        logic [USED_OUT_WIDTH-1:0]   used;
    } table_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          opcode = OP_COUNT;
    logic [MAC_WIDTH-1:0]          mac_key = '0;
    logic [INDEX_WIDTH-1:0]        read_index = '0;
    logic                          busy;
    logic                          done;
    logic [STATUS_WIDTH-1:0]       status;
    logic [INDEX_WIDTH-1:0]        entry_index;
    logic [MAC_WIDTH-1:0]          entry_mac;
    logic [COUNT_OUT_WIDTH-1:0]    packet_count;
    logic [USED_OUT_WIDTH-1:0]     entries_in_use;

    packet_beat_t                  packet_beats[$];
    table_result_t                 predicted_results[$];
    logic [MAC_WIDTH-1:0]          issued_keys[$];
    logic [MAC_WIDTH-1:0]          mirror_keys[DEPTH];
    logic [COUNT_OUT_WIDTH-1:0]    mirror_counts[DEPTH];
    int                            mirror_used = 0;
    int                            beat_total = 0;
    int                            beats_taken = 0;
    int                            errors = 0;
    int                            quiet_cycles = 0;

    mac_address_packet_counter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .mac_key        (mac_key),
        .read_index     (read_index),
        .done           (done),
        .status         (status),
        .entry_index    (entry_index),
        .entry_mac      (entry_mac),
        .packet_count   (packet_count),
        .entries_in_use (entries_in_use)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [MAC_WIDTH-1:0] random_mac();
        logic [MAC_WIDTH-1:0] m;
        m[47:32] = 16'($urandom_range(16'hFFFF));
        m[31:0]  = $urandom;
        return m;
    endfunction

    // Queues a beat and tracks which keys will end up in the table, in table order.
    function automatic void add_beat(opcode_t op, logic [MAC_WIDTH-1:0] key,
                                     logic [INDEX_WIDTH-1:0] idx);
        packet_beat_t b;
        bit known;
        b.op  = op;
        b.key = key;
        b.idx = idx;
        packet_beats.push_back(b);
        known = 1'b0;
        if (op == OP_COUNT)
        begin
            foreach (issued_keys[i])
                if (issued_keys[i] == key)
                    known = 1'b1;
            if (!known && issued_keys.size() < DEPTH)
                issued_keys.push_back(key);
        end
    endfunction

    // Looks the key up in the mirrored table and applies the count or read.
    function automatic table_result_t lookup_and_count(packet_beat_t b);
        table_result_t r;
        r.st  = ST_READ_EMPTY;
        r.idx = b.idx;
        r.mac = '0;
        r.cnt = '0;
        if (b.op == OP_READ)
        begin
            if (int'(b.idx) < mirror_used)
            begin
                r.st  = ST_READ_OK;
                r.mac = mirror_keys[b.idx];
                r.cnt = mirror_counts[b.idx];
            end
        end
        else
        begin
            r.st = ST_FULL;
            for (int i = 0; i < mirror_used; i++)
            begin
                if (r.st == ST_FULL && mirror_keys[i] == b.key)
                begin
                    if (mirror_counts[i] != '1)
                        mirror_counts[i] = mirror_counts[i] + 1'b1;
                    r.st  = ST_HIT;
                    r.idx = INDEX_WIDTH'(i);
                    r.mac = mirror_keys[i];
                    r.cnt = mirror_counts[i];
                end
            end
            if (r.st == ST_FULL && mirror_used < DEPTH)
            begin
                mirror_keys[mirror_used]   = b.key;
                mirror_counts[mirror_used] = 1;
                r.st  = ST_NEW;
                r.idx = INDEX_WIDTH'(mirror_used);
                r.mac = b.key;
                r.cnt = 1;
                mirror_used++;
            end
            else if (r.st == ST_FULL)
            begin
                r.idx = '0;
                r.mac = b.key;
                r.cnt = '0;
            end
        end
        r.used = USED_OUT_WIDTH'(mirror_used);
        return r;
    endfunction

    task automatic compare_field(string field, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
        end
    endtask

    // Driver: a new beat is presented after the current one is taken or while start is low.
    always @(posedge clk)
    begin : drive_beats
        packet_beat_t nxt;
        int idle_pct;
        bit load;
        if (rst_n && (!start || !busy))
        begin
            if (packet_beats.size() * 3 > beat_total * 2)
                idle_pct = 11;
            else if (packet_beats.size() * 3 > beat_total)
                idle_pct = 84;
            else
                idle_pct = 0;
            load = packet_beats.size() != 0 && $urandom_range(99) >= idle_pct;
            if (load)
            begin
                nxt = packet_beats.pop_front();
                start      <= 1'b1;
                opcode     <= nxt.op;
                mac_key    <= nxt.key;
                read_index <= nxt.idx;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: checks each result against the oldest prediction, then predicts any new beat.
    always @(posedge clk)
    begin : watch_results
        table_result_t want;
        packet_beat_t taken;
        if (rst_n)
        begin
            if (done)
            begin
                if (predicted_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with no beat outstanding, status %0d",
                             $time, status);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    compare_field("status", want.st, status);
                    compare_field("entry_index", want.idx, entry_index);
                    compare_field("entry_mac", want.mac, entry_mac);
                    compare_field("packet_count", want.cnt, packet_count);
                    compare_field("entries_in_use", want.used, entries_in_use);
                end
            end
            if (start && !busy)
            begin
                taken.op  = opcode_t'(opcode);
                taken.key = mac_key;
                taken.idx = read_index;
                predicted_results.push_back(lookup_and_count(taken));
                beats_taken++;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no beat or result for %0d cycles", $time, quiet_cycles);
                $display("[mac_address_packet_counter] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int r;
        int idx;
        // Empty-table reads, then both key extremes as new entries and as hits.
        add_beat(OP_READ, random_mac(), 7'd0);
        add_beat(OP_READ, random_mac(), 7'd127);
        add_beat(OP_COUNT, 48'h0, 7'd127);
        add_beat(OP_COUNT, 48'hFFFF_FFFF_FFFF, 7'd0);
        add_beat(OP_COUNT, 48'h0, 7'h55);
        add_beat(OP_COUNT, 48'hFFFF_FFFF_FFFF, 7'h2A);
        add_beat(OP_COUNT, 48'hAAAA_AAAA_AAAA, 7'd0);
        add_beat(OP_COUNT, 48'h5555_5555_5555, 7'd127);
        add_beat(OP_READ, 48'hFFFF_FFFF_FFFF, 7'd0);
        add_beat(OP_READ, 48'h0, 7'd3);
        add_beat(OP_READ, random_mac(), 7'd4);
        add_beat(OP_READ, random_mac(), 7'd127);
        add_beat(OP_COUNT, 48'h5555_5555_5555, 7'd0);
        add_beat(OP_COUNT, 48'h0000_0000_0001, 7'd0);
        add_beat(OP_COUNT, 48'h8000_0000_0000, 7'd0);
        add_beat(OP_READ, random_mac(), 7'd5);
        add_beat(OP_READ, random_mac(), 7'd6);
        // New keys fill the table part way through, so later misses are dropped as full.
        // Saturating a 32-bit count is out of reach in a run of this length.
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            r = $urandom_range(99);
            if (r < 20)
                add_beat(OP_COUNT, random_mac(), 7'($urandom_range(127)));
            else if (r < 75)
                add_beat(OP_COUNT, issued_keys[$urandom_range(issued_keys.size() - 1)],
                         7'($urandom_range(127)));
            else
            begin
                idx = issued_keys.size() < DEPTH ? issued_keys.size() : DEPTH - 1;
                if ($urandom_range(2) != 0)
                    idx = $urandom_range(DEPTH - 1);
                add_beat(OP_READ, random_mac(), 7'(idx));
            end
        end
        beat_total = packet_beats.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (beats_taken != beat_total || predicted_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("[mac_address_packet_counter] OK");
        else
            $display("[mac_address_packet_counter] ERROR");
        $finish;
    end

endmodule
